/* rtl/trmx_pkg.sv */
package trmx_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned OPC_W  = 5;
    localparam int unsigned REG_W  = 5;
    localparam int unsigned NREGS  = 32;

    localparam int unsigned OPC_LSB  = 11;
    localparam int unsigned DST_LSB  = 6;
    localparam int unsigned MODE_BIT = 5;
    localparam int unsigned SRC_LSB  = 0;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [REG_W-1:0]  reg_idx_t;

    typedef enum logic [OPC_W-1:0] {
        OP_NONE = 5'd0,
        OP_MOVE = 5'd1,
        OP_ADD  = 5'd2,
        OP_SUB  = 5'd3,
        OP_AND  = 5'd4,
        OP_OR   = 5'd5,
        OP_XOR  = 5'd6,
        OP_NOT  = 5'd7,
        OP_INC  = 5'd8,
        OP_DEC  = 5'd9,
        OP_CMP  = 5'd10
    } opcode_t;

    typedef struct packed {
        logic     en;
        reg_idx_t idx;
        word_t    value;
    } reg_write_t;

endpackage

/* rtl/tiny_register_machine_execute_core.sv */
// Executes one 16-bit instruction word per beat, in program order, against a
// 32 x 16 register file held in a memory with registered reads. An item goes
// from input beat to result beat through operand read, then execute and write
// back; a new item is taken every cycle while out_stall does not hold a result,
// and the last register write is forwarded to the following instruction, so
// back-to-back dependent instructions see the new value. The register file
// reads as zero after reset through per-register valid flags, so no clearing
// pass is needed. An all-zero word halts the machine: it and every later item
// return the halted program counter with halted set and no register write.
module tiny_register_machine_execute_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           instruction,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           pc,
    output logic                  write_enable,
    output logic [4:0]            write_index,
    output logic [15:0]           write_value,
    output logic                  zero_flag,
    output logic                  halted
);

    logic                                in_take;
    logic                                advance;

    trmx_pkg::word_t                     rf_mem [trmx_pkg::NREGS];
    logic [trmx_pkg::NREGS-1:0]          rf_valid_reg;
    logic [trmx_pkg::NREGS-1:0]          rf_valid_next;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    trmx_pkg::word_t                     s1_instr_reg;
    trmx_pkg::word_t                     rd_a_reg;
    trmx_pkg::word_t                     rd_b_reg;
    logic                                vld_a_reg;
    logic                                vld_b_reg;

    trmx_pkg::reg_write_t                fwd_reg;
    trmx_pkg::reg_write_t                fwd_next;

    trmx_pkg::word_t                     prog_cnt_reg;
    trmx_pkg::word_t                     prog_cnt_next;
    logic                                eq_flag_reg;
    logic                                eq_flag_next;
    logic                                stopped_reg;
    logic                                stopped_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    trmx_pkg::word_t                     pc_reg;
    trmx_pkg::reg_write_t                wr_out_reg;
    logic                                flag_out_reg;
    logic                                halt_out_reg;

    trmx_pkg::opcode_t                   opc;
    trmx_pkg::reg_idx_t                  dst;
    trmx_pkg::reg_idx_t                  src;
    logic                                reg_src;
    trmx_pkg::word_t                     op_a;
    trmx_pkg::word_t                     op_rb;
    trmx_pkg::word_t                     op_b;
    trmx_pkg::word_t                     res;
    logic                                we;
    logic                                halt_now;
    trmx_pkg::reg_write_t                wr_now;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // operand read, the stage ahead of execute
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_a_reg     <= rf_mem[instruction[trmx_pkg::DST_LSB +: trmx_pkg::REG_W]];
            rd_b_reg     <= rf_mem[instruction[trmx_pkg::SRC_LSB +: trmx_pkg::REG_W]];
            s1_instr_reg <= instruction;
        end
        if (wr_now.en)
        begin
            rf_mem[wr_now.idx] <= wr_now.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (in_take)
        begin
            vld_a_reg <= rf_valid_reg[instruction[trmx_pkg::DST_LSB +: trmx_pkg::REG_W]];
            vld_b_reg <= rf_valid_reg[instruction[trmx_pkg::SRC_LSB +: trmx_pkg::REG_W]];
        end
    end

    // decode and execute
    always_comb
    begin
        opc     = trmx_pkg::opcode_t'(s1_instr_reg[trmx_pkg::OPC_LSB +: trmx_pkg::OPC_W]);
        dst     = s1_instr_reg[trmx_pkg::DST_LSB +: trmx_pkg::REG_W];
        src     = s1_instr_reg[trmx_pkg::SRC_LSB +: trmx_pkg::REG_W];
        reg_src = s1_instr_reg[trmx_pkg::MODE_BIT];

        // take the last write when it hit this register, else the memory word (zero if never written)
        if (fwd_reg.en && fwd_reg.idx == dst)
        begin
            op_a = fwd_reg.value;
        end
        else
        begin
            op_a = vld_a_reg ? rd_a_reg : '0;
        end
        if (fwd_reg.en && fwd_reg.idx == src)
        begin
            op_rb = fwd_reg.value;
        end
        else
        begin
            op_rb = vld_b_reg ? rd_b_reg : '0;
        end
        op_b = reg_src ? op_rb : {{(trmx_pkg::WORD_W-trmx_pkg::REG_W){1'b0}}, src};

        halt_now     = stopped_reg || (s1_instr_reg == '0);
        res          = '0;
        we           = 1'b0;
        eq_flag_next = eq_flag_reg;

        unique case (opc)
            trmx_pkg::OP_MOVE: begin res = op_b;          we = 1'b1; end
            trmx_pkg::OP_ADD:  begin res = op_a + op_b;   we = 1'b1; end
            trmx_pkg::OP_SUB:  begin res = op_a - op_b;   we = 1'b1; end
            trmx_pkg::OP_AND:  begin res = op_a & op_b;   we = 1'b1; end
            trmx_pkg::OP_OR:   begin res = op_a | op_b;   we = 1'b1; end
            trmx_pkg::OP_XOR:  begin res = op_a ^ op_b;   we = 1'b1; end
            trmx_pkg::OP_NOT:  begin res = ~op_b;         we = 1'b1; end
            trmx_pkg::OP_INC:  begin res = op_a + 16'd1;  we = 1'b1; end
            trmx_pkg::OP_DEC:  begin res = op_a - 16'd1;  we = 1'b1; end
            trmx_pkg::OP_CMP:  eq_flag_next = (op_a == op_rb);
            default:           ;
        endcase

        if (halt_now || !s1_valid_reg || !advance)
        begin
            we           = 1'b0;
            res          = '0;
            eq_flag_next = eq_flag_reg;
        end

        wr_now.en    = we;
        wr_now.idx   = we ? dst : '0;
        wr_now.value = res;

        stopped_next  = stopped_reg;
        prog_cnt_next = prog_cnt_reg;
        if (s1_valid_reg && advance)
        begin
            stopped_next = halt_now;
            if (!halt_now)
            begin
                prog_cnt_next = prog_cnt_reg + 16'd1;
            end
        end

        fwd_next      = wr_now.en ? wr_now : fwd_reg;
        rf_valid_next = rf_valid_reg;
        if (wr_now.en)
        begin
            rf_valid_next[wr_now.idx] = 1'b1;
        end

        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = (s1_valid_reg && advance) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            fwd_reg       <= '0;
            prog_cnt_reg  <= '0;
            eq_flag_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rf_valid_reg  <= rf_valid_next;
            fwd_reg       <= fwd_next;
            prog_cnt_reg  <= prog_cnt_next;
            eq_flag_reg   <= eq_flag_next;
            stopped_reg   <= stopped_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            pc_reg       <= prog_cnt_reg;
            wr_out_reg   <= wr_now;
            flag_out_reg <= eq_flag_next;
            halt_out_reg <= halt_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pc           = pc_reg;
    assign write_enable = wr_out_reg.en;
    assign write_index  = wr_out_reg.idx;
    assign write_value  = wr_out_reg.value;
    assign zero_flag    = flag_out_reg;
    assign halted       = halt_out_reg;

    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !write_enable)
        else $error("halted result carries a register write");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt state cleared");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_index == '0 && write_value == '0)
        else $error("idle write fields not zero");

    a_pc_hold_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> prog_cnt_reg == $past(prog_cnt_reg))
        else $error("program counter moved after halt");

endmodule
